// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the I2C master bit engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define I2CBE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define I2CBE_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("assertion failed");
`else
`define I2CBE_ASSERT(lbl, clk, rstn, prop)
`define I2CBE_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// File: hw/rtl/i2cbe_pkg.sv
// Types, codes and sequence tables of the I2C master bit engine.
`timescale 1ns / 1ps
package i2cbe_pkg;

    localparam int UNIT_COUNT_BITS_DEF = 16;
    localparam int UNIT_W = 16;
    localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET = 16'd50;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_SACK  = 3'd5;
    localparam logic [2:0] OP_GACK  = 3'd6;

    localparam logic [3:0] ST_SCL0  = 4'd0;
    localparam logic [3:0] ST_SCL1  = 4'd1;
    localparam logic [3:0] ST_SDA0  = 4'd2;
    localparam logic [3:0] ST_SDA1  = 4'd3;
    localparam logic [3:0] ST_SDAD  = 4'd4;
    localparam logic [3:0] ST_SDAA  = 4'd5;
    localparam logic [3:0] ST_SCL1S = 4'd6;
    localparam logic [3:0] ST_SCL1R = 4'd7;
    localparam logic [3:0] ST_SCL1A = 4'd8;
    localparam logic [3:0] ST_DLY   = 4'd9;
    localparam logic [3:0] ST_DLYL  = 4'd10;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic       is_cmd;
        logic [2:0] op;
        logic [7:0] data_byte;
        logic       ack_bit;
        logic       sda_level;
    } item_t;

    typedef struct packed {
        logic       rejected;
        logic       ack_seen;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       scl;
    } res_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_out_t;

    function automatic logic [3:0] seq_step(input logic [2:0] op, input logic [2:0] ph);
        logic [3:0] c;
        c = ST_SCL0;
        case (op)
            OP_START: begin
                case (ph)
                    3'd1: c = ST_SDA1;
                    3'd2: c = ST_SCL1;
                    3'd3: c = ST_DLY;
                    3'd4: c = ST_SDA0;
                    3'd5: c = ST_DLY;
                    default: c = ST_SCL0;
                endcase
            end
            OP_STOP: begin
                case (ph)
                    3'd0: c = ST_SCL0;
                    3'd1: c = ST_SDA0;
                    3'd2: c = ST_SCL1;
                    3'd4: c = ST_SDA1;
                    default: c = ST_DLY;
                endcase
            end
            OP_WRITE: begin
                case (ph)
                    3'd1: c = ST_SDAD;
                    3'd2: c = ST_DLY;
                    3'd3: c = ST_DLY;
                    3'd4: c = ST_SCL1S;
                    3'd5: c = ST_DLYL;
                    default: c = ST_SCL0;
                endcase
            end
            OP_READ: begin
                case (ph)
                    3'd1: c = ST_SDA1;
                    3'd3: c = ST_DLY;
                    3'd4: c = ST_DLY;
                    3'd5: c = ST_SCL1R;
                    3'd6: c = ST_DLYL;
                    default: c = ST_SCL0;
                endcase
            end
            OP_SACK: begin
                case (ph)
                    3'd1: c = ST_SDAA;
                    3'd2: c = ST_DLY;
                    3'd3: c = ST_DLY;
                    3'd4: c = ST_SCL1;
                    3'd5: c = ST_DLY;
                    default: c = ST_SCL0;
                endcase
            end
            OP_GACK: begin
                case (ph)
                    3'd1: c = ST_SDA1;
                    3'd2: c = ST_DLY;
                    3'd3: c = ST_DLY;
                    3'd4: c = ST_SCL1A;
                    3'd5: c = ST_DLY;
                    default: c = ST_SCL0;
                endcase
            end
            default: c = ST_SCL0;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] seq_len(input logic [2:0] op);
        logic [3:0] n;
        n = (op == OP_READ) ? 4'd8 : 4'd7;
        return n;
    endfunction

    function automatic logic [2:0] loop_at(input logic [2:0] op);
        logic [2:0] p;
        p = (op == OP_READ) ? 3'd2 : 3'd0;
        return p;
    endfunction

endpackage

// File: hw/rtl/i2c_master_bit_engine_top.sv
// Top level of the I2C master bit engine: front end, item queue and bus sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Each input item is one tick of the bus timer and yields exactly one result item
// with the SCL and SDA levels for that tick. The engine accepts one item per clock
// cycle while the queue is not full and delivers one result per cycle while the
// output is not stalled; an item is written into the two-entry queue and then into
// the result register, where its result becomes valid. The
// sequencer advances one step per item, its state being the only loop, and a delay
// step holds the lines for unit_ticks items (0 is taken as 1). Write unit_ticks
// only while no command is running and all results have been taken.
module i2c_master_bit_engine_top #(
    parameter int UNIT_COUNT_BITS = i2cbe_pkg::UNIT_COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // unit_ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // data_byte[7:0], ack_bit[8], sda_level[9], zero pad
    input  logic [2:0]  s_tuser,       // func[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata        // scl[0], sda_drive[1], busy_res[2], done_res[3],
                                       // read_data[11:4], ack_seen[12], rejected[13], zero pad
);

    i2cbe_pkg::item_t  item;
    i2cbe_pkg::q_out_t head;
    i2cbe_pkg::res_t   res;
    logic              q_full, pop;

    i2cbe_front u_front (
        .func    (s_tuser),
        .payload (s_tdata),
        .item    (item)
    );

    assign s_tready = !q_full;

    i2cbe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_item (item),
        .full      (q_full),
        .pop       (pop),
        .head      (head)
    );

    i2cbe_back #(
        .UNIT_COUNT_BITS (UNIT_COUNT_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head        (head),
        .pop         (pop),
        .res         (res),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready)
    );

    assign m_tdata = {2'b00, res.rejected, res.ack_seen, res.read_data,
                      res.done_res, res.busy_res, res.sda_drive, res.scl};

    `I2CBE_ASSERT_NEVER(a_done_not_busy, aclk, aresetn, m_tvalid && res.done_res && res.busy_res)
    `I2CBE_ASSERT(a_rej_in_cmd, aclk, aresetn, (m_tvalid && res.rejected) |-> (res.busy_res || res.done_res))
    `I2CBE_ASSERT_NEVER(a_no_overwrite, aclk, aresetn, pop && m_tvalid && !m_tready)
    `I2CBE_ASSERT_NEVER(a_pop_empty, aclk, aresetn, pop && !head.valid)

endmodule

// File: hw/rtl/i2cbe_front.sv
// Front end: unpacks an input item and classifies its command code.
`timescale 1ns / 1ps
module i2cbe_front (
    input  logic [2:0]     func,
    input  logic [15:0]    payload,
    output i2cbe_pkg::item_t item
);

    always_comb begin
        item.is_cmd    = func inside {[i2cbe_pkg::OP_START:i2cbe_pkg::OP_GACK]};
        item.op        = item.is_cmd ? func : i2cbe_pkg::OP_NONE;
        item.data_byte = payload[7:0];
        item.ack_bit   = payload[8];
        item.sda_level = payload[9];
    end

endmodule

// File: hw/rtl/i2cbe_queue.sv
// Short queue of classified items between the front end and the sequencer.
`timescale 1ns / 1ps
module i2cbe_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  i2cbe_pkg::item_t push_item,
    output logic             full,
    input  logic             pop,
    output i2cbe_pkg::q_out_t head
);

    localparam int PW = (i2cbe_pkg::QUEUE_DEPTH > 1) ? $clog2(i2cbe_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(i2cbe_pkg::QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(i2cbe_pkg::QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(i2cbe_pkg::QUEUE_DEPTH);

    i2cbe_pkg::item_t mem_reg [i2cbe_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full     = (cnt_reg == DEPTH_C);
    assign do_push  = push && !full;
    assign do_pop   = pop && (cnt_reg != '0);
    assign head.valid = (cnt_reg != '0);
    assign head.item  = mem_reg[rd_reg];

    always_comb begin
        wr_next  = do_push ? ((wr_reg == LAST) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = do_pop ? ((rd_reg == LAST) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/i2cbe_back.sv
// Back end: bus sequencer that runs one step per item, with the result register.
`timescale 1ns / 1ps
module i2cbe_back #(
    parameter int UNIT_COUNT_BITS = i2cbe_pkg::UNIT_COUNT_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    input  i2cbe_pkg::q_out_t head,
    output logic              pop,
    output i2cbe_pkg::res_t   res,
    output logic              res_valid,
    input  logic              res_ready
);

    localparam int W = UNIT_COUNT_BITS;

    logic [15:0]  unit_reg;
    logic [2:0]   op_reg, op_next;
    logic [2:0]   phase_reg, phase_next;
    logic [3:0]   bit_reg, bit_next;
    logic [7:0]   sh_reg, sh_next;
    logic [W-1:0] wait_reg, wait_next;
    logic         scl_reg, scl_next;
    logic         sda_reg, sda_next;
    logic         ack_reg, ack_next;
    logic [7:0]   last_reg, last_next;
    logic         outv_reg;
    i2cbe_pkg::res_t res_reg;

    logic         fire, run, adv, done, rej;
    logic [3:0]   code, code_nxt, nxt, bit_inc;
    logic [15:0]  unit_m1;
    logic [31:0]  unit_ext;
    logic [W-1:0] wait_load;

    assign fire      = head.valid && (!outv_reg || res_ready);
    assign pop       = fire;
    assign res       = res_reg;
    assign res_valid = outv_reg;

    assign unit_m1   = ((unit_reg == '0) ? 16'd1 : unit_reg) - 16'd1;
    assign unit_ext  = {16'd0, unit_m1};
    assign wait_load = unit_ext[W-1:0];

    always_comb begin
        op_next    = op_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        sh_next    = sh_reg;
        wait_next  = wait_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        last_next  = last_reg;
        run        = 1'b0;
        rej        = 1'b0;
        done       = 1'b0;
        adv        = 1'b0;
        code       = i2cbe_pkg::ST_SCL0;
        code_nxt   = i2cbe_pkg::ST_SCL0;
        nxt        = 4'd0;
        bit_inc    = 4'd0;
        if (fire) begin
            if (op_reg == i2cbe_pkg::OP_NONE) begin
                if (head.item.is_cmd) begin
                    op_next    = head.item.op;
                    phase_next = 3'd0;
                    bit_next   = 4'd0;
                    wait_next  = '0;
                    if (head.item.op == i2cbe_pkg::OP_WRITE) begin
                        sh_next = head.item.data_byte;
                    end else if (head.item.op == i2cbe_pkg::OP_SACK) begin
                        sh_next = {7'd0, head.item.ack_bit};
                    end else begin
                        sh_next = 8'd0;
                    end
                    run = 1'b1;
                end
            end else begin
                rej = head.item.is_cmd;
                run = 1'b1;
            end
        end
        if (run) begin
            code = i2cbe_pkg::seq_step(op_next, phase_next);
            nxt  = {1'b0, phase_next} + 4'd1;
            adv  = 1'b1;
            case (code)
                i2cbe_pkg::ST_SCL0: scl_next = 1'b0;
                i2cbe_pkg::ST_SCL1: scl_next = 1'b1;
                i2cbe_pkg::ST_SDA0: sda_next = 1'b0;
                i2cbe_pkg::ST_SDA1: sda_next = 1'b1;
                i2cbe_pkg::ST_SDAD: sda_next = sh_next[7];
                i2cbe_pkg::ST_SDAA: sda_next = sh_next[0];
                i2cbe_pkg::ST_SCL1S: begin
                    scl_next = 1'b1;
                    sh_next  = {sh_next[6:0], 1'b0};
                end
                i2cbe_pkg::ST_SCL1R: begin
                    scl_next = 1'b1;
                    sh_next  = {sh_next[6:0], head.item.sda_level};
                end
                i2cbe_pkg::ST_SCL1A: begin
                    scl_next = 1'b1;
                    ack_next = head.item.sda_level;
                end
                default: begin
                    if (wait_next != '0) begin
                        wait_next = wait_next - 1'b1;
                        adv       = 1'b0;
                    end else if (code == i2cbe_pkg::ST_DLYL) begin
                        bit_inc  = bit_next + 4'd1;
                        bit_next = bit_inc;
                        if (bit_inc < i2cbe_pkg::BITS_PER_BYTE) begin
                            nxt = {1'b0, i2cbe_pkg::loop_at(op_next)};
                        end
                    end
                end
            endcase
            if (adv) begin
                if (nxt >= i2cbe_pkg::seq_len(op_next)) begin
                    if (op_next == i2cbe_pkg::OP_READ) begin
                        last_next = sh_next;
                    end
                    op_next    = i2cbe_pkg::OP_NONE;
                    phase_next = 3'd0;
                    done       = 1'b1;
                end else begin
                    phase_next = nxt[2:0];
                    code_nxt   = i2cbe_pkg::seq_step(op_next, nxt[2:0]);
                    if (code_nxt == i2cbe_pkg::ST_DLY || code_nxt == i2cbe_pkg::ST_DLYL) begin
                        wait_next = wait_load;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_reg  <= i2cbe_pkg::UNIT_TICKS_RESET;
            op_reg    <= i2cbe_pkg::OP_NONE;
            phase_reg <= '0;
            bit_reg   <= '0;
            sh_reg    <= '0;
            wait_reg  <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ack_reg   <= 1'b0;
            last_reg  <= '0;
            outv_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unit_reg <= cfg_wr_data;
            end
            op_reg    <= op_next;
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            sh_reg    <= sh_next;
            wait_reg  <= wait_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
            last_reg  <= last_next;
            if (fire) begin
                outv_reg <= 1'b1;
            end else if (res_ready) begin
                outv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg.scl       <= scl_next;
            res_reg.sda_drive <= sda_next;
            res_reg.busy_res  <= (op_next != i2cbe_pkg::OP_NONE);
            res_reg.done_res  <= done;
            res_reg.read_data <= last_next;
            res_reg.ack_seen  <= ack_next;
            res_reg.rejected  <= rej;
        end
    end

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the I2C master bit engine: directed rows, then random bus traffic.
`timescale 1ns / 1ps
module tb_top;

    localparam int          CNT_BITS        = i2cbe_pkg::UNIT_COUNT_BITS_DEF;
    localparam logic [2:0]  OP_UNUSED       = 3'd7;
    localparam logic [15:0] DIRECTED_UNIT   = 16'd1;
    localparam logic [95:0] PHASE_UNITS     = {16'd3, 16'd5, 16'd7, 16'd2, 16'd0, 16'd1};
    localparam int          NUM_PHASES      = 6;
    localparam int          TICKS_PER_PHASE = 250;
    localparam int          SETTLE_CYCLES   = 6;
    localparam int          CYCLE_LIMIT     = 200000;

    typedef enum logic [3:0] {
        SC_CLK_LO, SC_CLK_HI, SC_DAT_LO, SC_DAT_HI, SC_DAT_BIT, SC_DAT_ACK,
        SC_CLK_HI_SHIFT, SC_CLK_HI_RECV, SC_CLK_HI_ACK, SC_WAIT, SC_WAIT_LOOP
    } step_e;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] data;
        logic       ack;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  data;
        logic        ack;
        logic        sda;
        logic        settle;
        logic        pinned;
        logic [15:0] want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    // Shadow of the engine state.
    logic [2:0]          p_op;
    logic [2:0]          p_phase;
    logic [3:0]          p_bits;
    logic [7:0]          p_shift;
    logic [CNT_BITS-1:0] p_wait;
    logic                p_scl;
    logic                p_sda;
    logic                p_ack;
    logic [7:0]          p_rx;
    logic [15:0]         unit_cfg;

    logic [15:0] line_states_q [$];
    cmd_t        cmd_script [$];
    logic        pin_on;
    logic [15:0] pin_exp;
    int          mismatches = 0;
    int          burst_left = 0;
    int          rdy_left = 0;
    int          stall_left = 0;
    int          cycle_cnt = 0;

    i2c_master_bit_engine_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic step_e step_of(input logic [2:0] op, input logic [2:0] ph);
        logic [31:0] s;
        case (op)
            i2cbe_pkg::OP_START: s = {SC_CLK_LO, SC_CLK_LO, SC_WAIT, SC_DAT_LO,
                                      SC_WAIT, SC_CLK_HI, SC_DAT_HI, SC_CLK_LO};
            i2cbe_pkg::OP_STOP:  s = {SC_WAIT, SC_WAIT, SC_WAIT, SC_DAT_HI,
                                      SC_WAIT, SC_CLK_HI, SC_DAT_LO, SC_CLK_LO};
            i2cbe_pkg::OP_WRITE: s = {SC_CLK_LO, SC_CLK_LO, SC_WAIT_LOOP, SC_CLK_HI_SHIFT,
                                      SC_WAIT, SC_WAIT, SC_DAT_BIT, SC_CLK_LO};
            i2cbe_pkg::OP_READ:  s = {SC_CLK_LO, SC_WAIT_LOOP, SC_CLK_HI_RECV, SC_WAIT,
                                      SC_WAIT, SC_CLK_LO, SC_DAT_HI, SC_CLK_LO};
            i2cbe_pkg::OP_SACK:  s = {SC_CLK_LO, SC_CLK_LO, SC_WAIT, SC_CLK_HI,
                                      SC_WAIT, SC_WAIT, SC_DAT_ACK, SC_CLK_LO};
            i2cbe_pkg::OP_GACK:  s = {SC_CLK_LO, SC_CLK_LO, SC_WAIT, SC_CLK_HI_ACK,
                                      SC_WAIT, SC_WAIT, SC_DAT_HI, SC_CLK_LO};
            default:             s = '0;
        endcase
        return step_e'(s[ph*4 +: 4]);
    endfunction

    function automatic logic [CNT_BITS-1:0] unit_reload();
        logic [31:0] u;
        u = (unit_cfg == 16'd0) ? 32'd1 : {16'd0, unit_cfg};
        u = u - 32'd1;
        return u[CNT_BITS-1:0];
    endfunction

    function automatic logic go_step(input logic [3:0] nxt);
        step_e c;
        if (nxt >= ((p_op == i2cbe_pkg::OP_READ) ? 4'd8 : 4'd7)) begin
            if (p_op == i2cbe_pkg::OP_READ)
                p_rx = p_shift;
            p_op = i2cbe_pkg::OP_NONE;
            p_phase = 3'd0;
            return 1'b1;
        end
        p_phase = nxt[2:0];
        c = step_of(p_op, p_phase);
        if (c == SC_WAIT || c == SC_WAIT_LOOP)
            p_wait = unit_reload();
        return 1'b0;
    endfunction

    function automatic logic run_one(input logic sda_in);
        step_e c;
        c = step_of(p_op, p_phase);
        case (c)
            SC_CLK_LO:  p_scl = 1'b0;
            SC_CLK_HI:  p_scl = 1'b1;
            SC_DAT_LO:  p_sda = 1'b0;
            SC_DAT_HI:  p_sda = 1'b1;
            SC_DAT_BIT: p_sda = p_shift[7];
            SC_DAT_ACK: p_sda = p_shift[0];
            SC_CLK_HI_SHIFT: begin
                p_scl = 1'b1;
                p_shift = {p_shift[6:0], 1'b0};
            end
            SC_CLK_HI_RECV: begin
                p_scl = 1'b1;
                p_shift = {p_shift[6:0], sda_in};
            end
            SC_CLK_HI_ACK: begin
                p_scl = 1'b1;
                p_ack = sda_in;
            end
            default: begin
                if (p_wait != '0) begin
                    p_wait = p_wait - 1'b1;
                    return 1'b0;
                end
                if (c == SC_WAIT_LOOP) begin
                    p_bits = p_bits + 4'd1;
                    if (p_bits < i2cbe_pkg::BITS_PER_BYTE)
                        return go_step((p_op == i2cbe_pkg::OP_READ) ? 4'd2 : 4'd0);
                end
            end
        endcase
        return go_step({1'b0, p_phase} + 4'd1);
    endfunction

    function automatic logic [15:0] bus_tick(input logic [2:0] f, input logic [7:0] d,
                                             input logic a, input logic sda_in);
        i2cbe_pkg::res_t r;
        logic rej;
        logic fin;
        rej = 1'b0;
        fin = 1'b0;
        if (p_op == i2cbe_pkg::OP_NONE) begin
            if (f != i2cbe_pkg::OP_NONE && f != OP_UNUSED) begin
                p_op = f;
                p_phase = 3'd0;
                p_bits = 4'd0;
                p_wait = '0;
                p_shift = (f == i2cbe_pkg::OP_WRITE) ? d :
                          (f == i2cbe_pkg::OP_SACK) ? {7'd0, a} : 8'd0;
                fin = run_one(sda_in);
            end
        end else begin
            rej = (f != i2cbe_pkg::OP_NONE && f != OP_UNUSED);
            fin = run_one(sda_in);
        end
        r.scl = p_scl;
        r.sda_drive = p_sda;
        r.busy_res = (p_op != i2cbe_pkg::OP_NONE);
        r.done_res = fin;
        r.read_data = p_rx;
        r.ack_seen = p_ack;
        r.rejected = rej;
        return {2'b00, r};
    endfunction

    task automatic note_miss(input logic [15:0] want, input logic [15:0] got, input bit orphan);
        i2cbe_pkg::res_t w;
        i2cbe_pkg::res_t g;
        w = want[13:0];
        g = got[13:0];
        mismatches++;
        if (mismatches <= 10) begin
            if (orphan)
                $display("%0t: result item %h arrived with nothing expected", $time, got);
            else
                $display({"%0t: want scl %b sda %b busy %b done %b rd %h ack %b rej %b pad %b,",
                          " got scl %b sda %b busy %b done %b rd %h ack %b rej %b pad %b"},
                         $time, w.scl, w.sda_drive, w.busy_res, w.done_res, w.read_data,
                         w.ack_seen, w.rejected, want[15:14], g.scl, g.sda_drive, g.busy_res,
                         g.done_res, g.read_data, g.ack_seen, g.rejected, got[15:14]);
        end
    endtask

    always @(posedge aclk) begin : track
        logic [15:0] want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want = bus_tick(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[9]);
                line_states_q.push_back(pin_on ? pin_exp : want);
            end
            if (m_tvalid && m_tready) begin
                if (line_states_q.size() == 0) begin
                    note_miss(16'h0000, m_tdata, 1'b1);
                end else begin
                    want = line_states_q.pop_front();
                    if (m_tdata !== want)
                        note_miss(want, m_tdata, 1'b0);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (rdy_left != 0) begin
            rdy_left--;
            m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            rdy_left = $urandom_range(1, 24);
            stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
            m_tready <= 1'b1;
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("[i2c_master_bit_engine_top] ERROR");
        $finish;
    end

    task automatic send_tick(input logic [2:0] f, input logic [7:0] d, input logic a,
                             input logic sda);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tuser <= f;
        s_tdata <= {6'd0, sda, a, d};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        @(negedge aclk);
    endtask

    task automatic finish_cmd(input bit noisy, input logic sda);
        logic [2:0] f;
        while (p_op != i2cbe_pkg::OP_NONE) begin
            f = i2cbe_pkg::OP_NONE;
            if (noisy) begin
                case ($urandom_range(0, 29))
                    0: f = 3'($urandom_range(i2cbe_pkg::OP_START, i2cbe_pkg::OP_GACK));
                    1: f = OP_UNUSED;
                    default: f = i2cbe_pkg::OP_NONE;
                endcase
            end
            send_tick(f, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      noisy ? 1'($urandom_range(0, 1)) : sda);
        end
    endtask

    function automatic void add_cmd(input logic [2:0] f, input logic [7:0] d, input logic a);
        cmd_script.push_back(cmd_t'{func: f, data: d, ack: a});
    endfunction

    function automatic void plan_transfer();
        int n;
        add_cmd(i2cbe_pkg::OP_START, 8'h00, 1'b0);
        add_cmd(i2cbe_pkg::OP_WRITE, 8'($urandom_range(0, 255)), 1'b0);
        add_cmd(i2cbe_pkg::OP_GACK, 8'h00, 1'b0);
        n = $urandom_range(1, 3);
        repeat (n) begin
            if ($urandom_range(0, 1) == 0) begin
                add_cmd(i2cbe_pkg::OP_WRITE, 8'($urandom_range(0, 255)), 1'b0);
                add_cmd(i2cbe_pkg::OP_GACK, 8'h00, 1'b0);
            end else begin
                add_cmd(i2cbe_pkg::OP_READ, 8'h00, 1'b0);
                add_cmd(i2cbe_pkg::OP_SACK, 8'h00, 1'($urandom_range(0, 1)));
            end
        end
        add_cmd(i2cbe_pkg::OP_STOP, 8'h00, 1'b0);
    endfunction

    task automatic send_random();
        cmd_t c;
        logic [2:0] f;
        logic [7:0] d;
        logic a;
        d = 8'($urandom_range(0, 255));
        a = 1'($urandom_range(0, 1));
        f = i2cbe_pkg::OP_NONE;
        if (p_op == i2cbe_pkg::OP_NONE) begin
            if ($urandom_range(0, 9) == 0) begin
                f = 3'($urandom_range(0, 7));
            end else if ($urandom_range(0, 2) != 0) begin
                if (cmd_script.size() == 0)
                    plan_transfer();
                c = cmd_script.pop_front();
                f = c.func;
                d = c.data;
                a = c.ack;
            end
        end else begin
            case ($urandom_range(0, 24))
                0: f = 3'($urandom_range(i2cbe_pkg::OP_START, i2cbe_pkg::OP_GACK));
                1: f = OP_UNUSED;
                default: f = i2cbe_pkg::OP_NONE;
            endcase
        end
        send_tick(f, d, a, 1'($urandom_range(0, 1)));
    endtask

    task automatic set_unit(input logic [15:0] v);
        s_tvalid <= 1'b0;
        while (line_states_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_data <= v;
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        unit_cfg = v;
    endtask

    initial begin : main
        row_t rows [$];
        logic [15:0] u;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 16'd0;
        s_tvalid = 1'b0;
        s_tdata = 16'd0;
        s_tuser = i2cbe_pkg::OP_NONE;
        m_tready = 1'b0;
        pin_on = 1'b0;
        pin_exp = 16'd0;
        p_op = i2cbe_pkg::OP_NONE;
        p_phase = 3'd0;
        p_bits = 4'd0;
        p_shift = 8'd0;
        p_wait = '0;
        p_scl = 1'b1;
        p_sda = 1'b1;
        p_ack = 1'b0;
        p_rx = 8'd0;
        unit_cfg = i2cbe_pkg::UNIT_TICKS_RESET;

        //                    func                  data   ack   sda   settle pinned want
        rows.push_back(row_t'{i2cbe_pkg::OP_NONE,  8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 16'h0003});
        rows.push_back(row_t'{OP_UNUSED,           8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, 16'h0003});
        rows.push_back(row_t'{i2cbe_pkg::OP_START, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 16'h0006});
        rows.push_back(row_t'{i2cbe_pkg::OP_WRITE, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000});
        rows.push_back(row_t'{i2cbe_pkg::OP_GACK,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000});
        rows.push_back(row_t'{i2cbe_pkg::OP_WRITE, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 16'h0000});
        rows.push_back(row_t'{i2cbe_pkg::OP_GACK,  8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000});
        rows.push_back(row_t'{i2cbe_pkg::OP_WRITE, 8'hA5, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000});
        rows.push_back(row_t'{i2cbe_pkg::OP_GACK,  8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000});
        rows.push_back(row_t'{i2cbe_pkg::OP_READ,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000});
        rows.push_back(row_t'{i2cbe_pkg::OP_SACK,  8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000});
        rows.push_back(row_t'{i2cbe_pkg::OP_READ,  8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, 16'h0000});
        rows.push_back(row_t'{i2cbe_pkg::OP_SACK,  8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0000});
        rows.push_back(row_t'{i2cbe_pkg::OP_STOP,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000});
        rows.push_back(row_t'{i2cbe_pkg::OP_START, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000});
        rows.push_back(row_t'{i2cbe_pkg::OP_WRITE, 8'h5A, 1'b0, 1'b1, 1'b0, 1'b1, 16'h2006});
        rows.push_back(row_t'{OP_UNUSED,           8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000});
        rows.push_back(row_t'{i2cbe_pkg::OP_STOP,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000});

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) begin
            pin_on = rows[i].pinned;
            pin_exp = rows[i].want;
            send_tick(rows[i].func, rows[i].data, rows[i].ack, rows[i].sda);
            pin_on = 1'b0;
            if (rows[i].settle) begin
                finish_cmd(1'b0, rows[i].sda);
                // Only the first command runs at the reset unit length.
                if (unit_cfg != DIRECTED_UNIT)
                    set_unit(DIRECTED_UNIT);
            end
        end

        for (int k = 0; k < NUM_PHASES; k++) begin
            u = PHASE_UNITS[k*16 +: 16];
            set_unit(u);
            repeat (TICKS_PER_PHASE) send_random();
            finish_cmd(1'b1, 1'b1);
        end

        s_tvalid <= 1'b0;
        while (line_states_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0)
            $display("[i2c_master_bit_engine_top] OK");
        else
            $display("[i2c_master_bit_engine_top] ERROR");
        $finish;
    end

endmodule
